### hdl/lsc_pkg.sv
// Package for the light sphere culling core.
// Holds the input and result payload structs and fixed field widths.
// No dependencies.
`default_nettype none

package lsc_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned CountW = 7;

  localparam logic       FuncWrite = 1'b0;
  localparam logic       FuncQuery = 1'b1;
  localparam logic [1:0] KindPoint = 2'd0;
  localparam logic [1:0] KindSpot  = 2'd1;
  localparam logic [1:0] KindDir   = 2'd2;

  typedef struct packed {
    logic                     func;
    logic [SlotW-1:0]         slot;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic [CoordW-1:0]        reach;
    logic [1:0]               kind;
    logic                     enable;
    logic [CoordW-1:0]        query_radius;
  } lsc_in_t;

  typedef struct packed {
    logic [SlotW-1:0] visible_slot;
    logic             hit;
    logic             last;
  } lsc_out_t;

endpackage

`default_nettype wire

### hdl/light_sphere_culling_core.sv
// Light sphere culling core: light table memory, walk sequencer and one
// shared squaring multiplier. Depends on lsc_pkg.
`default_nettype none

// A write item (func 0) stores one light in a table slot and gives no
// result. A query item (func 1) walks slots 0 to min(light_count,
// MAX_LIGHTS)-1 and returns one result per visible light, the final one
// flagged last, or a single hit=0 last=1 marker if none is visible. The
// input is stalled for the whole query. Disabled slots and slots of
// unknown kind are skipped, directional lights are visible without a
// distance test, and point and spot lights are tested by distance: the
// three squared differences and the squared reach sum go one after another
// through a single 25x25 multiplier. Output stalls can lengthen a query.
// Light data sits in a table with one write port and a registered read
// port; enable flags reset to zero.
module light_sphere_culling_core #(
  parameter int unsigned MAX_LIGHTS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire lsc_pkg::lsc_in_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output lsc_pkg::lsc_out_t              out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [lsc_pkg::CountW-1:0] cfg_data
);
  import lsc_pkg::*;

  localparam int unsigned AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int unsigned CW = $clog2(MAX_LIGHTS + 1);
  localparam int unsigned MW = CoordW + 1;
  localparam int unsigned PW = 2 * MW;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRead  = 4'd1;
  localparam logic [3:0] StCheck = 4'd2;
  localparam logic [3:0] StD1    = 4'd3;
  localparam logic [3:0] StD2    = 4'd4;
  localparam logic [3:0] StD3    = 4'd5;
  localparam logic [3:0] StD4    = 4'd6;
  localparam logic [3:0] StCmp   = 4'd7;
  localparam logic [3:0] StVis   = 4'd8;
  localparam logic [3:0] StFlush = 4'd9;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [CoordW-1:0]        reach;
    logic [1:0]               kind;
  } light_t;

  // Control state
  logic [3:0]            state_r, state_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         walk_r, walk_nxt;
  logic                  have_pend_r, have_pend_nxt;
  logic [AW-1:0]         pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lsc_out_t              out_data_r, out_data_nxt;
  logic [CountW-1:0]     light_count_r;
  logic [MAX_LIGHTS-1:0] en_r;

  // Datapath registers
  logic signed [CoordW-1:0] cx_r, cy_r, cz_r;
  logic [CoordW-1:0]        radius_r;
  light_t                   rd_r;
  logic [MW-1:0]            mag_r, mag_nxt;
  logic [PW-1:0]            prod_r;
  logic [PW-1:0]            acc_r, acc_nxt;
  logic                     mul_en;

  light_t mem [MAX_LIGHTS];

  logic          in_xfer;
  logic          wr_en;
  logic          out_free;
  logic [AW-1:0] rd_addr;
  logic          cur_en;

  assign in_stall  = (state_r != StIdle);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign rd_addr   = idx_r[AW-1:0];
  assign cur_en    = en_r[rd_addr];
  assign wr_en     = in_xfer && (in_data.func == FuncWrite) &&
                     ({1'b0, in_data.slot} < CountW'(MAX_LIGHTS));

  // Absolute difference of two signed coordinates, exact in MW bits
  function automatic logic [MW-1:0] abs_diff(input logic signed [CoordW-1:0] a,
                                             input logic signed [CoordW-1:0] b);
    logic signed [MW-1:0] d;
    d = MW'(a) - MW'(b);
    abs_diff = d[MW-1] ? MW'(-d) : MW'(d);
  endfunction

  // Light table: write on a write transfer, read the walk slot every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_data.slot[AW-1:0]] <= '{x: in_data.pos_x, y: in_data.pos_y,
                                     z: in_data.pos_z, reach: in_data.reach,
                                     kind: in_data.kind};
    end
    rd_r <= mem[rd_addr];
  end

  // Sequencer and shared multiplier control
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    walk_nxt      = walk_r;
    have_pend_nxt = have_pend_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mag_nxt       = mag_r;
    acc_nxt       = acc_r;
    mul_en        = 1'b0;
    case (state_r)
      StIdle: begin
        if (in_xfer && (in_data.func == FuncQuery)) begin
          idx_nxt       = '0;
          have_pend_nxt = 1'b0;
          walk_nxt      = (light_count_r > CountW'(MAX_LIGHTS)) ?
                          CW'(MAX_LIGHTS) : CW'(light_count_r);
          state_nxt     = StRead;
        end
      end
      StRead: begin
        // wait for the table read, or finish the walk
        state_nxt = (idx_r == walk_r) ? StFlush : StCheck;
      end
      StCheck: begin
        if (!cur_en) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = StRead;
        end else if (rd_r.kind == KindDir) begin
          state_nxt = StVis;
        end else if (rd_r.kind inside {KindPoint, KindSpot}) begin
          mag_nxt   = abs_diff(rd_r.x, cx_r);
          state_nxt = StD1;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = StRead;
        end
      end
      StD1: begin
        mul_en    = 1'b1;
        mag_nxt   = abs_diff(rd_r.y, cy_r);
        state_nxt = StD2;
      end
      StD2: begin
        mul_en    = 1'b1;
        acc_nxt   = prod_r;
        mag_nxt   = abs_diff(rd_r.z, cz_r);
        state_nxt = StD3;
      end
      StD3: begin
        mul_en    = 1'b1;
        acc_nxt   = acc_r + prod_r;
        mag_nxt   = MW'(radius_r) + MW'(rd_r.reach);
        state_nxt = StD4;
      end
      StD4: begin
        mul_en    = 1'b1;
        acc_nxt   = acc_r + prod_r;
        state_nxt = StCmp;
      end
      StCmp: begin
        if (acc_r <= prod_r) begin
          state_nxt = StVis;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = StRead;
        end
      end
      StVis: begin
        // hold one hit back so the final one can carry last
        if (!have_pend_r) begin
          have_pend_nxt = 1'b1;
          pend_nxt      = rd_addr;
          idx_nxt       = idx_r + 1'b1;
          state_nxt     = StRead;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{visible_slot: SlotW'(pend_r), hit: 1'b1, last: 1'b0};
          pend_nxt      = rd_addr;
          idx_nxt       = idx_r + 1'b1;
          state_nxt     = StRead;
        end
      end
      StFlush: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (have_pend_r) begin
            out_data_nxt = '{visible_slot: SlotW'(pend_r), hit: 1'b1, last: 1'b1};
          end else begin
            out_data_nxt = '{visible_slot: '0, hit: 1'b0, last: 1'b1};
          end
          have_pend_nxt = 1'b0;
          state_nxt     = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= StIdle;
      idx_r         <= '0;
      walk_r        <= '0;
      have_pend_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      light_count_r <= '0;
      en_r          <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      walk_r      <= walk_nxt;
      have_pend_r <= have_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        light_count_r <= cfg_data;
      end
      if (wr_en) begin
        en_r[in_data.slot[AW-1:0]] <= in_data.enable;
      end
    end
  end

  // Payload registers: query latch, pending hit, output and datapath
  always_ff @(posedge clk) begin
    if (in_xfer && (in_data.func == FuncQuery)) begin
      cx_r     <= in_data.pos_x;
      cy_r     <= in_data.pos_y;
      cz_r     <= in_data.pos_z;
      radius_r <= in_data.query_radius;
    end
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
    mag_r      <= mag_nxt;
    acc_r      <= acc_nxt;
    if (mul_en) begin
      prod_r <= mag_r * mag_r;
    end
  end

  // Checks
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> out_data.last)
    else $error("empty marker without last");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != StIdle) |-> (idx_r <= walk_r))
    else $error("walk index beyond walk length");

  a_vis_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StVis) |-> cur_en)
    else $error("disabled light reported visible");

  a_dist_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StD1) |-> ((rd_r.kind == KindPoint) || (rd_r.kind == KindSpot)))
    else $error("distance test on non point or spot light");

  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StFlush && out_free) |=> (state_r == StIdle && !have_pend_r && out_valid))
    else $error("query end not delivered");

endmodule

`default_nettype wire

### test/tb_light_sphere_culling_core.sv
// Self-checking testbench for light_sphere_culling_core: light table writes,
// sphere visibility queries and light_count settings, checked by a scoreboard
// that keeps its own copy of the table. Depends on lsc_pkg and the core.
module tb_light_sphere_culling_core;
  import lsc_pkg::*;

  localparam int unsigned MAX_LIGHTS    = 64;
  localparam logic [1:0]  KindOther     = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned QUIET_LIMIT   = 5000;
  localparam int unsigned PHASE_ITEMS   = 50;
  localparam int unsigned REPORT_MAX    = 10;

  localparam logic [CoordW-1:0] CoordMax = 24'h7FFFFF;
  localparam logic [CoordW-1:0] CoordMin = 24'h800000;
  localparam logic [CoordW-1:0] ReachMax = 24'hFFFFFF;

  // Light table copy and queue of expected culling results
  class culling_scoreboard;
    logic signed [CoordW-1:0] x_tab [MAX_LIGHTS];
    logic signed [CoordW-1:0] y_tab [MAX_LIGHTS];
    logic signed [CoordW-1:0] z_tab [MAX_LIGHTS];
    logic [CoordW-1:0]        reach_tab [MAX_LIGHTS];
    logic [1:0]               kind_tab [MAX_LIGHTS];
    bit                       on_tab [MAX_LIGHTS];
    logic [CountW-1:0]        walk_count;
    lsc_out_t                 expected_q [$];
    int unsigned              failures;
    int unsigned              seen;

    function new();
      foreach (on_tab[i]) on_tab[i] = 1'b0;
      walk_count = '0;
      failures   = 0;
      seen       = 0;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= REPORT_MAX) $display("MISMATCH: %s", msg);
    endfunction

    function void set_count(logic [CountW-1:0] value);
      walk_count = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Update the table on a write, or work out the visible slots of a query
    function void note_input(lsc_in_t item);
      int unsigned walk;
      int unsigned i;
      longint      dx, dy, dz, dist2, span;
      bit          vis;
      int unsigned visible [$];
      lsc_out_t    res;
      if (item.func == FuncWrite) begin
        x_tab[item.slot]     = item.pos_x;
        y_tab[item.slot]     = item.pos_y;
        z_tab[item.slot]     = item.pos_z;
        reach_tab[item.slot] = item.reach;
        kind_tab[item.slot]  = item.kind;
        on_tab[item.slot]    = item.enable;
        return;
      end
      walk = (walk_count > MAX_LIGHTS) ? MAX_LIGHTS : walk_count;
      for (i = 0; i < walk; i++) begin
        if (!on_tab[i]) continue;
        vis = 1'b0;
        if (kind_tab[i] == KindDir) begin
          vis = 1'b1;
        end else if (kind_tab[i] == KindPoint || kind_tab[i] == KindSpot) begin
          dx    = longint'($signed(x_tab[i])) - longint'($signed(item.pos_x));
          dy    = longint'($signed(y_tab[i])) - longint'($signed(item.pos_y));
          dz    = longint'($signed(z_tab[i])) - longint'($signed(item.pos_z));
          dist2 = dx * dx + dy * dy + dz * dz;
          span  = longint'({1'b0, item.query_radius}) + longint'({1'b0, reach_tab[i]});
          vis   = (dist2 <= span * span);
        end
        if (vis) visible = {visible, i};
      end
      // Empty answer: one marker with hit low
      if (visible.size() == 0) begin
        res.visible_slot = '0;
        res.hit          = 1'b0;
        res.last         = 1'b1;
        expected_q = {expected_q, res};
        return;
      end
      foreach (visible[k]) begin
        res.visible_slot = visible[k][SlotW-1:0];
        res.hit          = 1'b1;
        res.last         = (k == visible.size() - 1);
        expected_q = {expected_q, res};
      end
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(lsc_out_t got);
      lsc_out_t want;
      seen++;
      if (expected_q.size() == 0) begin
        flag($sformatf("result %0d with nothing expected: slot %0d hit %0d last %0d",
                       seen, got.visible_slot, got.hit, got.last));
        return;
      end
      want = expected_q.pop_front();
      if (got.visible_slot !== want.visible_slot || got.hit !== want.hit ||
          got.last !== want.last)
        flag($sformatf("result %0d: expected slot %0d hit %0d last %0d, got slot %0d hit %0d last %0d",
                       seen, want.visible_slot, want.hit, want.last,
                       got.visible_slot, got.hit, got.last));
    endfunction

    function void close();
      if (expected_q.size() != 0)
        flag($sformatf("%0d expected results never arrived", expected_q.size()));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  lsc_in_t           in_data;
  logic              out_valid;
  logic              out_stall;
  lsc_out_t          out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CountW-1:0] cfg_data;

  culling_scoreboard sb;
  int unsigned       quiet_cycles = 0;
  int unsigned       stall_left = 0;

  light_sphere_culling_core #(
    .MAX_LIGHTS(MAX_LIGHTS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Observe every transfer and count quiet cycles for the watchdog
  always @(posedge clk) begin : monitor
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        sb.note_input(in_data);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.set_count(cfg_data);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    @(posedge clk);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // Result side back-pressure: short and long stalls, with long free runs
  always @(posedge clk) begin : out_pace
    int unsigned r;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(1, 20);
      end else if (r < 85) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else if (r < 95) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(30, 80);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CoordW-1:0] rand_coord();
    if ($urandom_range(0, 99) < 75) return CoordW'($urandom_range(0, 6000)) - 24'd3000;
    return CoordW'($urandom());
  endfunction

  function automatic logic [CoordW-1:0] rand_reach();
    if ($urandom_range(0, 99) < 75) return CoordW'($urandom_range(0, 2000));
    return CoordW'($urandom());
  endfunction

  function automatic lsc_in_t light_item(logic [SlotW-1:0] slot, logic [CoordW-1:0] x,
                                         logic [CoordW-1:0] y, logic [CoordW-1:0] z,
                                         logic [CoordW-1:0] reach, logic [1:0] kind,
                                         logic enable);
    lsc_in_t item;
    item.func         = FuncWrite;
    item.slot         = slot;
    item.pos_x        = x;
    item.pos_y        = y;
    item.pos_z        = z;
    item.reach        = reach;
    item.kind         = kind;
    item.enable       = enable;
    item.query_radius = CoordW'($urandom());
    return item;
  endfunction

  // Query with the fields it ignores filled with noise
  function automatic lsc_in_t query_item(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                                         logic [CoordW-1:0] z, logic [CoordW-1:0] radius);
    lsc_in_t item;
    item.func         = FuncQuery;
    item.slot         = SlotW'($urandom());
    item.pos_x        = x;
    item.pos_y        = y;
    item.pos_z        = z;
    item.reach        = CoordW'($urandom());
    item.kind         = 2'($urandom());
    item.enable       = 1'($urandom());
    item.query_radius = radius;
    return item;
  endfunction

  function automatic lsc_in_t random_item();
    logic [SlotW-1:0] slot;
    logic [1:0]       kind;
    int unsigned      r;
    if ($urandom_range(0, 99) < 55)
      return query_item(rand_coord(), rand_coord(), rand_coord(), rand_reach());
    // Favour the low slots so that short walks still find lights
    slot = ($urandom_range(0, 1) != 0) ? SlotW'($urandom_range(0, 15)) : SlotW'($urandom());
    r    = $urandom_range(0, 99);
    kind = (r < 35) ? KindPoint : (r < 65) ? KindSpot : (r < 80) ? KindDir : KindOther;
    return light_item(slot, rand_coord(), rand_coord(), rand_coord(), rand_reach(), kind,
                      $urandom_range(0, 99) < 80);
  endfunction

  // Present one item and hold it until the transfer
  task automatic send_item(lsc_in_t item, bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid, wait for every expected result, then let the core go idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [CountW-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(logic [CountW-1:0] count);
    bit no_gap;
    settle();
    write_count(count);
    no_gap = ($urandom_range(0, 3) == 0);
    repeat (PHASE_ITEMS) send_item(random_item(), no_gap);
  endtask

  initial begin
    sb        = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Count still zero after reset: walk nothing, expect the empty marker
    send_item(query_item(24'd0, 24'd0, 24'd0, 24'd100), 1'b0);
    settle();
    write_count(7'd64);

    // Boundary lights: distance equal to and one past the summed reach
    send_item(light_item(6'd0, 24'd300, 24'd0, 24'd0, 24'd200, KindPoint, 1'b1), 1'b0);
    send_item(light_item(6'd1, 24'd0, -24'sd300, 24'd0, 24'd199, KindSpot, 1'b1), 1'b0);
    send_item(light_item(6'd2, CoordMax, CoordMax, CoordMax, 24'd0, KindDir, 1'b1), 1'b0);
    send_item(light_item(6'd3, 24'd0, 24'd0, 24'd0, ReachMax, KindOther, 1'b1), 1'b0);
    send_item(light_item(6'd4, 24'd0, 24'd0, 24'd0, ReachMax, KindPoint, 1'b0), 1'b0);
    send_item(light_item(6'd63, CoordMin, CoordMin, CoordMin, ReachMax, KindPoint, 1'b1),
              1'b0);
    send_item(light_item(6'd5, 24'd0, 24'd0, 24'd0, 24'd0, KindSpot, 1'b1), 1'b0);
    // 3-4-12 triangle scaled by 16: distance 208 against 100 + 108
    send_item(light_item(6'd6, 24'd48, 24'd64, 24'd192, 24'd108, KindPoint, 1'b1), 1'b0);

    send_item(query_item(24'd0, 24'd0, 24'd0, 24'd100), 1'b0);
    send_item(query_item(CoordMax, CoordMax, CoordMax, ReachMax), 1'b0);
    send_item(query_item(CoordMin, CoordMin, CoordMin, 24'd0), 1'b0);
    send_item(query_item(24'd0, 24'd0, 24'd0, 24'd0), 1'b0);

    // Disable the directional light: the far query then sees nothing
    send_item(light_item(6'd2, CoordMax, CoordMax, CoordMax, 24'd0, KindDir, 1'b0), 1'b0);
    send_item(query_item(CoordMax, CoordMax, CoordMax, 24'd0), 1'b0);

    // Count above the table size walks the whole table
    settle();
    write_count(7'd127);
    send_item(query_item(24'd0, 24'd0, 24'd0, 24'd100), 1'b0);

    random_phase(7'd0);
    random_phase(7'd1);
    random_phase(7'd64);
    random_phase(7'd127);
    random_phase(7'd65);
    random_phase(7'd8);
    random_phase(CountW'($urandom_range(2, 20)));
    random_phase(CountW'($urandom_range(0, 127)));

    settle();
    sb.close();
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
